[rtl/sps_pkg.sv]
package sps_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SCORE_W = 16;
    localparam int ID_W = 32;
    localparam int SUM_W = SCORE_W + CNT_W;
    localparam logic [SCORE_W-1:0] SCORE_ONE = 16'd32768;

    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_MIN_DRIFT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WSCAN,
        S_WRITE,
        S_SUM,
        S_RANK,
        S_DIV,
        S_DONE,
        S_OUT
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture input beat
        logic clr_idx;    // reset slot counters
        logic wscan;      // one step of the worst slot scan
        logic write;      // write the entry and update totals
        logic sum_step;   // one step of sum, min, max
        logic rank_step;  // one pair step of the rank scan
        logic div_start;  // begin mean and slope divisions
        logic div_step;   // one step of the dividers
        logic finish;     // latch trend registers
        logic show;       // present result
        logic empty;      // write empty-store trend
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic invalid;
        logic has_room;
        logic refuse;
        logic wscan_last;
        logic sum_last;
        logic rank_last;
        logic div_done;
        logic held_zero;
    } stat_t;

endpackage

[rtl/sps_ctrl.sv]
module sps_ctrl
    import sps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.clr_idx = 1'b1;
                    state_next = S_WSCAN;
                end
            end
            S_WSCAN:
            begin
                if (stat.invalid || stat.has_room)
                begin
                    state_next = stat.invalid ? S_OUT : S_WRITE;
                end
                else if (stat.wscan_last)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    cmd.wscan = 1'b1;
                end
            end
            S_WRITE:
            begin
                if (stat.refuse)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.write = 1'b1;
                    cmd.clr_idx = 1'b1;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (stat.held_zero)
                begin
                    cmd.empty = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.sum_step = 1'b1;
                    if (stat.sum_last)
                    begin
                        state_next = S_RANK;
                    end
                end
            end
            S_RANK:
            begin
                cmd.rank_step = 1'b1;
                if (stat.rank_last)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_OUT:
            begin
                cmd.show = 1'b1;
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_ready) |=> state_reg == S_OUT)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |=> state_reg == S_SUM)
        else $error("write not followed by trend pass");

endmodule

[rtl/sps_datapath.sv]
module sps_datapath
    import sps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic [15:0]        score,
    input  logic [31:0]        cost_micro,
    output logic [1:0]         status,
    output logic [4:0]         entry_count,
    output logic [31:0]        assigned_id,
    output logic [31:0]        eviction_total,
    output logic [47:0]        cost_total,
    output logic [15:0]        score_mean,
    output logic [15:0]        score_min,
    output logic [15:0]        score_max,
    output logic signed [16:0] score_slope,
    output logic               drifting
);

    logic [4:0]          cap_reg;
    logic signed [15:0]  thr_reg;
    logic [4:0]          mind_reg;

    logic [SCORE_W-1:0]  score_mem [CAPACITY];
    logic [ID_W-1:0]     id_mem [CAPACITY];

    logic [CNT_W-1:0]    held_reg;
    logic [31:0]         next_id_reg;
    logic [31:0]         evict_reg;
    logic [47:0]         cost_reg;
    logic [15:0]         mean_reg, min_reg, max_reg;
    logic signed [16:0]  slope_reg;

    logic [15:0]         in_score_reg;
    logic [31:0]         in_cost_reg;
    logic [1:0]          status_reg;
    logic [31:0]         id_out_reg;

    logic [SLOT_W-1:0]   worst_reg;
    logic [CNT_W-1:0]    i_reg, j_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [15:0]         mn_reg, mx_reg;
    logic [CNT_W-1:0]    rank_reg;
    logic signed [SUM_W:0] diff_reg;

    // Two restoring dividers sharing one step counter: mean and slope magnitudes one bit per step.
    logic [SUM_W-1:0]    mq_reg, mr_reg;
    logic [SUM_W-1:0]    sq_reg, sr_reg;
    logic                sneg_reg;
    logic [CNT_W-1:0]    n_reg, half_reg;
    logic [4:0]          dcnt_reg;

    logic [CNT_W-1:0]    cap_eff;
    logic [SLOT_W-1:0]   i_slot, j_slot;
    logic [SCORE_W-1:0]  si;
    logic [ID_W-1:0]     idi, idj;
    logic                j_before;
    logic [SUM_W-1:0]    mr_sh, sr_sh;

    always_comb
    begin
        if (cap_reg < 5'd2)
        begin
            cap_eff = CNT_W'(2);
        end
        else if (cap_reg > 5'(CAPACITY))
        begin
            cap_eff = CNT_W'(CAPACITY);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign i_slot = i_reg[SLOT_W-1:0];
    assign j_slot = j_reg[SLOT_W-1:0];
    assign si = score_mem[i_slot];
    assign idi = id_mem[i_slot];
    assign idj = id_mem[j_slot];
    assign j_before = (idj < idi) || (idj == idi && j_reg < i_reg);
    assign mr_sh = {mr_reg[SUM_W-2:0], mq_reg[SUM_W-1]};
    assign sr_sh = {sr_reg[SUM_W-2:0], sq_reg[SUM_W-1]};

    always_comb
    begin
        stat.invalid = in_score_reg > SCORE_ONE;
        stat.has_room = held_reg < cap_eff;
        stat.refuse = !stat.has_room && in_score_reg >= score_mem[worst_reg];
        // The scan is over once every held slot has been compared.
        stat.wscan_last = i_reg >= held_reg;
        stat.sum_last = (i_reg + CNT_W'(1)) >= held_reg;
        stat.rank_last = (i_reg + CNT_W'(1)) >= held_reg
            && (j_reg + CNT_W'(1)) >= held_reg;
        stat.div_done = dcnt_reg == 5'd0;
        stat.held_zero = held_reg == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 5'd16;
            thr_reg <= 16'sd6554;
            mind_reg <= 5'd4;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CAPACITY:  cap_reg <= cfg_data[4:0];
                REG_THRESHOLD: thr_reg <= cfg_data[15:0];
                REG_MIN_DRIFT: mind_reg <= cfg_data[4:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            score_mem[stat.has_room ? held_reg[SLOT_W-1:0] : worst_reg] <= in_score_reg;
            id_mem[stat.has_room ? held_reg[SLOT_W-1:0] : worst_reg] <= next_id_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            next_id_reg <= '0;
            evict_reg <= '0;
            cost_reg <= '0;
            mean_reg <= '0;
            min_reg <= SCORE_ONE;
            max_reg <= '0;
            slope_reg <= '0;
        end
        else
        begin
            if (cmd.write)
            begin
                if (stat.has_room)
                begin
                    held_reg <= held_reg + CNT_W'(1);
                end
                else
                begin
                    evict_reg <= evict_reg + 32'd1;
                end
                next_id_reg <= next_id_reg + 32'd1;
                cost_reg <= cost_reg + {16'd0, in_cost_reg};
            end
            if (cmd.empty)
            begin
                mean_reg <= '0;
                min_reg <= SCORE_ONE;
                max_reg <= '0;
                slope_reg <= '0;
            end
            if (cmd.finish)
            begin
                mean_reg <= mq_reg[15:0];
                min_reg <= mn_reg;
                max_reg <= mx_reg;
                if (n_reg < CNT_W'(2))
                begin
                    slope_reg <= '0;
                end
                else
                begin
                    slope_reg <= sneg_reg ? -$signed(sq_reg[16:0])
                                          : $signed(sq_reg[16:0]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_score_reg <= score;
            in_cost_reg <= cost_micro;
            status_reg <= (score > SCORE_ONE) ? ST_INVALID : ST_STORED;
            id_out_reg <= next_id_reg;
            worst_reg <= '0;
        end
        if (cmd.clr_idx)
        begin
            i_reg <= cmd.load ? CNT_W'(1) : '0;
            j_reg <= '0;
            sum_reg <= '0;
            mn_reg <= SCORE_ONE;
            mx_reg <= '0;
            rank_reg <= '0;
            diff_reg <= '0;
        end
        if (cmd.wscan)
        begin
            if (si > score_mem[worst_reg])
            begin
                worst_reg <= i_slot;
            end
            i_reg <= i_reg + CNT_W'(1);
        end
        if (cmd.sum_step)
        begin
            sum_reg <= sum_reg + SUM_W'(si);
            if (si < mn_reg) mn_reg <= si;
            if (si > mx_reg) mx_reg <= si;
            i_reg <= stat.sum_last ? '0 : i_reg + CNT_W'(1);
        end
        if (cmd.rank_step)
        begin
            if ((j_reg + CNT_W'(1)) >= held_reg)
            begin
                // Rank of slot i is complete once j has passed every slot.
                if ((rank_reg + CNT_W'(j_before)) < (held_reg >> 1))
                begin
                    diff_reg <= diff_reg - (SUM_W + 1)'(si);
                end
                else if ((rank_reg + CNT_W'(j_before)) >= held_reg - (held_reg >> 1))
                begin
                    diff_reg <= diff_reg + (SUM_W + 1)'(si);
                end
                rank_reg <= '0;
                j_reg <= '0;
                i_reg <= i_reg + CNT_W'(1);
            end
            else
            begin
                rank_reg <= rank_reg + CNT_W'(j_before);
                j_reg <= j_reg + CNT_W'(1);
            end
        end
        if (cmd.div_start)
        begin
            mq_reg <= sum_reg;
            mr_reg <= '0;
            sneg_reg <= diff_reg < 0;
            sq_reg <= diff_reg < 0 ? SUM_W'(-diff_reg) : SUM_W'(diff_reg);
            sr_reg <= '0;
            n_reg <= held_reg;
            half_reg <= held_reg >> 1;
            dcnt_reg <= 5'(SUM_W);
        end
        if (cmd.div_step)
        begin
            if (mr_sh >= SUM_W'(n_reg))
            begin
                mr_reg <= mr_sh - SUM_W'(n_reg);
                mq_reg <= {mq_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                mr_reg <= mr_sh;
                mq_reg <= {mq_reg[SUM_W-2:0], 1'b0};
            end
            if (half_reg != '0 && sr_sh >= SUM_W'(half_reg))
            begin
                sr_reg <= sr_sh - SUM_W'(half_reg);
                sq_reg <= {sq_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                sr_reg <= sr_sh;
                sq_reg <= {sq_reg[SUM_W-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 5'd1;
        end
    end

    logic [1:0] status_show;
    assign status_show = (status_reg == ST_STORED && stat.refuse && !cmd.empty
                          && held_reg >= cap_eff && id_out_reg == next_id_reg)
                         ? ST_REFUSED : status_reg;

    assign status = status_show;
    assign entry_count = 5'(held_reg);
    assign assigned_id = id_out_reg;
    assign eviction_total = evict_reg;
    assign cost_total = cost_reg;
    assign score_mean = mean_reg;
    assign score_min = min_reg;
    assign score_max = max_reg;
    assign score_slope = slope_reg;
    assign drifting = (5'(held_reg) >= mind_reg) && (slope_reg > 17'(thr_reg));

    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(CAPACITY))
        else $error("held count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |=> next_id_reg == $past(next_id_reg) + 32'd1)
        else $error("id not advanced on store");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> min_reg <= max_reg)
        else $error("trend min above max");

endmodule

[rtl/score_priority_store_with_trend.sv]
// An invalid score goes from the input beat straight to the result beat; a refused
// item or a replacement first passes the worst slot scan, and every stored item
// then runs the sum, the pairwise id rank scan and the divisions before its result.
// One item in flight; the pairwise id rank scan sets the rate, and the next
// input beat is taken in the cycle after the result beat is accepted.
// Reset (rst_n low, asynchronous) empties the store, clears totals and trend.
module score_priority_store_with_trend
    import sps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        score,
    input  logic [31:0]        cost_micro,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [4:0]         entry_count,
    output logic [31:0]        assigned_id,
    output logic [31:0]        eviction_total,
    output logic [47:0]        cost_total,
    output logic [15:0]        score_mean,
    output logic [15:0]        score_min,
    output logic [15:0]        score_max,
    output logic signed [16:0] score_slope,
    output logic               drifting
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    sps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sps_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .score          (score),
        .cost_micro     (cost_micro),
        .status         (status),
        .entry_count    (entry_count),
        .assigned_id    (assigned_id),
        .eviction_total (eviction_total),
        .cost_total     (cost_total),
        .score_mean     (score_mean),
        .score_min      (score_min),
        .score_max      (score_max),
        .score_slope    (score_slope),
        .drifting       (drifting)
    );

endmodule
